// ----- hdl/isbd_pkg.sv -----
`default_nettype none

package isbd_pkg;

    // keystream period and position width
    localparam int KEY_PERIOD = 4864;
    localparam int POS_W      = 13;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(KEY_PERIOD - 1);

    // period split as 256 * HI_MOD, upper part of the position runs 0..HI_MOD-1
    localparam int HI_MOD = KEY_PERIOD / 256;
    localparam int HI_W   = 5;

    // item widths
    localparam int BYTE_W   = 8;
    localparam int OFFS_W   = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    // key table, indexed by the low byte of the keystream index
    localparam logic [7:0] KEY_TABLE [256] = '{
        8'hdf, 8'h56, 8'h25, 8'h4e, 8'h87, 8'h75, 8'hcf, 8'h85, 8'h05, 8'hb7, 8'h9f, 8'h4c,
        8'hf5, 8'h47, 8'h5e, 8'h4a, 8'h87, 8'h02, 8'h74, 8'h1c, 8'he9, 8'hf0, 8'h46, 8'hcf,
        8'he0, 8'h2b, 8'h81, 8'h58, 8'h99, 8'h1a, 8'h8b, 8'hef, 8'h78, 8'hc0, 8'hef, 8'h4d,
        8'h1c, 8'hb5, 8'hd5, 8'h51, 8'h65, 8'hfb, 8'hf9, 8'he0, 8'hf6, 8'h0a, 8'h0f, 8'h4a,
        8'hd0, 8'h2a, 8'h70, 8'hf2, 8'hc6, 8'he3, 8'hfe, 8'he3, 8'hdf, 8'h8b, 8'ha2, 8'ha7,
        8'hf3, 8'hd4, 8'hd7, 8'h75, 8'hc5, 8'h40, 8'h9f, 8'h41, 8'h8a, 8'hd4, 8'h74, 8'h47,
        8'h56, 8'h34, 8'hd4, 8'hae, 8'hca, 8'hd4, 8'h7b, 8'h97, 8'hff, 8'h00, 8'h48, 8'h2b,
        8'h3d, 8'ha1, 8'h48, 8'h85, 8'hff, 8'ha1, 8'hc2, 8'hae, 8'h88, 8'h87, 8'h6c, 8'hc1,
        8'h12, 8'h85, 8'h1d, 8'hb3, 8'hae, 8'h8c, 8'hd5, 8'h34, 8'h81, 8'h7e, 8'hec, 8'hf7,
        8'ha1, 8'h1b, 8'hc8, 8'h17, 8'h67, 8'hbc, 8'hf5, 8'h6a, 8'h87, 8'heb, 8'hc7, 8'ha4,
        8'hb1, 8'h12, 8'h19, 8'h24, 8'h5c, 8'hff, 8'ha9, 8'h87, 8'h23, 8'hbd, 8'h5c, 8'h6a,
        8'hea, 8'h1d, 8'h61, 8'h32, 8'haa, 8'ha9, 8'h21, 8'hcd, 8'h6b, 8'h05, 8'hb6, 8'h84,
        8'h96, 8'h97, 8'h6b, 8'h4c, 8'h42, 8'h31, 8'ha9, 8'h25, 8'ha3, 8'h7a, 8'hdc, 8'h72,
        8'h2f, 8'hf5, 8'h4a, 8'hb4, 8'h45, 8'h7d, 8'h80, 8'h87, 8'h19, 8'hcb, 8'h6c, 8'hc3,
        8'hf1, 8'h84, 8'h75, 8'hae, 8'h0d, 8'h0a, 8'h88, 8'h32, 8'h28, 8'h50, 8'h78, 8'hab,
        8'hab, 8'h0a, 8'hce, 8'heb, 8'h5c, 8'h0f, 8'h2d, 8'hc7, 8'hcf, 8'h8a, 8'h5b, 8'h7b,
        8'h3b, 8'h0e, 8'h9d, 8'h0a, 8'he8, 8'h8d, 8'hd4, 8'h88, 8'h82, 8'h94, 8'h03, 8'h26,
        8'h56, 8'h54, 8'h90, 8'h99, 8'h58, 8'hb5, 8'hd6, 8'h88, 8'hfd, 8'ha4, 8'h6b, 8'hb3,
        8'hcd, 8'hbf, 8'hc9, 8'had, 8'h77, 8'h67, 8'h27, 8'hb2, 8'h16, 8'hbc, 8'h2e, 8'hbc,
        8'h5f, 8'h87, 8'h5d, 8'hf3, 8'h7e, 8'h16, 8'h5b, 8'h2d, 8'h01, 8'h1f, 8'h36, 8'h63,
        8'h63, 8'hf4, 8'h87, 8'h06, 8'hc2, 8'h0e, 8'ha3, 8'hc9, 8'hff, 8'ha1, 8'h7f, 8'hb2,
        8'h6d, 8'h95, 8'h8c, 8'hef
    };

endpackage

`default_nettype wire

// ----- hdl/image_stream_byte_decipher.sv -----
// An accepted item passes through the input register, then the result register,
// which drives m_tdata and m_tlast.
// Throughput: one item per cycle unless the result side stalls; the keystream position
// is updated as each item moves into the result register, so consecutive items need no bubble.
// Reset (aresetn low at a clock edge) empties both registers and sets the
// keystream position to zero.
`default_nettype none

module image_stream_byte_decipher
    import isbd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // cipher_byte[7:0], start_offset[39:8]
    input  wire logic                s_tuser,   // restart
    input  wire logic                s_tlast,   // last_of_run
    // result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // plain_byte[7:0]
    output logic                     m_tlast    // run_end
);

    logic [BYTE_W-1:0] s_cipher;
    logic [OFFS_W-1:0] s_offset;

    // offset mod period: fold upper 24 bits mod HI_MOD
    logic [11:0]       fold1;
    logic [8:0]        fold2;
    logic [14:0]       q_prod;
    logic [4:0]        q_est;
    logic [8:0]        rem_raw;
    logic [5:0]        rem6;
    logic [HI_W-1:0]   rem_hi;
    logic [POS_W-1:0]  start_pos;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_cipher_reg;
    logic              in_restart_reg;
    logic [POS_W-1:0]  in_pos_reg;
    logic              in_last_reg;

    // keystream state
    logic [POS_W-1:0]  key_pos_reg;
    logic [POS_W-1:0]  key_pos_next;

    // decipher path
    logic              advance;
    logic [POS_W-1:0]  cur_pos;
    logic [8:0]        key_idx;
    logic [2:0]        rot;
    logic [7:0]        xor_byte;
    logic [15:0]       rot_word;

    // result register
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    assign s_cipher = s_tdata[BYTE_W-1:0];
    assign s_offset = s_tdata[BYTE_W +: OFFS_W];

    // 2^8 mod 19 = 9 and 2^16 mod 19 = 5, so fold bytes by those weights
    assign fold1 = 12'({4'd0, s_offset[31:24]} * 12'd5)
                 + 12'({4'd0, s_offset[23:16]} * 12'd9)
                 + {4'd0, s_offset[15:8]};
    assign fold2 = 9'({5'd0, fold1[11:8]} * 9'd9) + {1'b0, fold1[7:0]};

    // quotient estimate 53/1024 stays below 1/19, so the remainder lands in 0..37
    assign q_prod  = {6'd0, fold2} * 15'd53;
    assign q_est   = q_prod[14:10];
    assign rem_raw = fold2 - 9'({4'd0, q_est} * 9'(HI_MOD));
    assign rem6    = rem_raw[5:0];
    assign rem_hi  = (rem6 >= 6'(HI_MOD)) ? HI_W'(rem6 - 6'(HI_MOD)) : rem6[HI_W-1:0];
    assign start_pos = {rem_hi, s_offset[7:0]};

    // handshake: either stage moves when the stage after it is free
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // position select, key index and decipher
    assign cur_pos  = in_restart_reg ? in_pos_reg : key_pos_reg;
    assign key_idx  = {1'b0, cur_pos[7:0]} + {4'd0, cur_pos[12:8]};
    assign rot      = key_idx[5:3];
    assign xor_byte = in_cipher_reg ^ KEY_TABLE[key_idx[7:0]];
    assign rot_word = {xor_byte, xor_byte} >> rot;

    // next position wraps at the end of the period
    assign key_pos_next = (cur_pos == POS_LAST) ? '0 : cur_pos + POS_W'(1);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_cipher_reg  <= s_cipher;
            in_restart_reg <= s_tuser;
            in_pos_reg     <= start_pos;
            in_last_reg    <= s_tlast;
        end
    end

    // result register and keystream position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            key_pos_reg   <= '0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                key_pos_reg <= key_pos_next;
            end
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= rot_word[7:0];
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/isbd_checker.sv -----
`default_nettype none

module isbd_checker
    import isbd_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic                s_tuser,
    input wire logic                s_tlast,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tlast
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a ready sink never blocks the source
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // restart at offset zero uses the first key byte without rotation
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && s_tdata[S_DATA_W-1:BYTE_W] == '0
        ##1 m_tready
        |=> m_tvalid && m_tdata == ($past(s_tdata[7:0], 2) ^ KEY_TABLE[0])
            && m_tlast == $past(s_tlast, 2))
        else $error("wrong result for restart at offset zero");

endmodule

bind image_stream_byte_decipher isbd_checker u_isbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import isbd_pkg::*;

    // one directed row: item fields, plus a typed-in result where it is obvious
    typedef struct packed {
        logic [7:0]  cipher;
        logic        restart;
        logic [31:0] offset;
        logic        last;
        logic        typed;
        logic [7:0]  plain;
    } stim_row_t;

    // one expected result item
    typedef struct packed {
        logic [7:0] plain;
        logic       run_end;
    } plain_result_t;

    localparam int RANDOM_ITEMS = 850;
    localparam int DIRECTED_ROWS = 20;
    localparam logic [12:0] POS_TOP = 13'(KEY_PERIOD - 1);

    // keystream key bytes, kept here independently of the design
    localparam logic [7:0] KEY_BYTES [256] = '{
        8'hdf, 8'h56, 8'h25, 8'h4e, 8'h87, 8'h75, 8'hcf, 8'h85, 8'h05, 8'hb7, 8'h9f, 8'h4c,
        8'hf5, 8'h47, 8'h5e, 8'h4a, 8'h87, 8'h02, 8'h74, 8'h1c, 8'he9, 8'hf0, 8'h46, 8'hcf,
        8'he0, 8'h2b, 8'h81, 8'h58, 8'h99, 8'h1a, 8'h8b, 8'hef, 8'h78, 8'hc0, 8'hef, 8'h4d,
        8'h1c, 8'hb5, 8'hd5, 8'h51, 8'h65, 8'hfb, 8'hf9, 8'he0, 8'hf6, 8'h0a, 8'h0f, 8'h4a,
        8'hd0, 8'h2a, 8'h70, 8'hf2, 8'hc6, 8'he3, 8'hfe, 8'he3, 8'hdf, 8'h8b, 8'ha2, 8'ha7,
        8'hf3, 8'hd4, 8'hd7, 8'h75, 8'hc5, 8'h40, 8'h9f, 8'h41, 8'h8a, 8'hd4, 8'h74, 8'h47,
        8'h56, 8'h34, 8'hd4, 8'hae, 8'hca, 8'hd4, 8'h7b, 8'h97, 8'hff, 8'h00, 8'h48, 8'h2b,
        8'h3d, 8'ha1, 8'h48, 8'h85, 8'hff, 8'ha1, 8'hc2, 8'hae, 8'h88, 8'h87, 8'h6c, 8'hc1,
        8'h12, 8'h85, 8'h1d, 8'hb3, 8'hae, 8'h8c, 8'hd5, 8'h34, 8'h81, 8'h7e, 8'hec, 8'hf7,
        8'ha1, 8'h1b, 8'hc8, 8'h17, 8'h67, 8'hbc, 8'hf5, 8'h6a, 8'h87, 8'heb, 8'hc7, 8'ha4,
        8'hb1, 8'h12, 8'h19, 8'h24, 8'h5c, 8'hff, 8'ha9, 8'h87, 8'h23, 8'hbd, 8'h5c, 8'h6a,
        8'hea, 8'h1d, 8'h61, 8'h32, 8'haa, 8'ha9, 8'h21, 8'hcd, 8'h6b, 8'h05, 8'hb6, 8'h84,
        8'h96, 8'h97, 8'h6b, 8'h4c, 8'h42, 8'h31, 8'ha9, 8'h25, 8'ha3, 8'h7a, 8'hdc, 8'h72,
        8'h2f, 8'hf5, 8'h4a, 8'hb4, 8'h45, 8'h7d, 8'h80, 8'h87, 8'h19, 8'hcb, 8'h6c, 8'hc3,
        8'hf1, 8'h84, 8'h75, 8'hae, 8'h0d, 8'h0a, 8'h88, 8'h32, 8'h28, 8'h50, 8'h78, 8'hab,
        8'hab, 8'h0a, 8'hce, 8'heb, 8'h5c, 8'h0f, 8'h2d, 8'hc7, 8'hcf, 8'h8a, 8'h5b, 8'h7b,
        8'h3b, 8'h0e, 8'h9d, 8'h0a, 8'he8, 8'h8d, 8'hd4, 8'h88, 8'h82, 8'h94, 8'h03, 8'h26,
        8'h56, 8'h54, 8'h90, 8'h99, 8'h58, 8'hb5, 8'hd6, 8'h88, 8'hfd, 8'ha4, 8'h6b, 8'hb3,
        8'hcd, 8'hbf, 8'hc9, 8'had, 8'h77, 8'h67, 8'h27, 8'hb2, 8'h16, 8'hbc, 8'h2e, 8'hbc,
        8'h5f, 8'h87, 8'h5d, 8'hf3, 8'h7e, 8'h16, 8'h5b, 8'h2d, 8'h01, 8'h1f, 8'h36, 8'h63,
        8'h63, 8'hf4, 8'h87, 8'h06, 8'hc2, 8'h0e, 8'ha3, 8'hc9, 8'hff, 8'ha1, 8'h7f, 8'hb2,
        8'h6d, 8'h95, 8'h8c, 8'hef
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // cipher_byte[7:0], start_offset[39:8]
    logic                s_tuser;   // restart
    logic                s_tlast;   // last_of_run
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // plain_byte[7:0]
    logic                m_tlast;   // run_end

    plain_result_t pending_plain [$];
    logic [12:0]   key_pos;
    int            mismatch_count;
    int            sent_count;
    int            recv_count;

    // directed items: reset state, field extremes, restart, wrap and run boundaries
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // first item after reset uses position zero
        '{8'h00, 1'b0, 32'h0000_0000, 1'b0, 1'b1, 8'hdf},
        // offset ignored without restart
        '{8'hff, 1'b0, 32'hffff_ffff, 1'b0, 1'b0, 8'h00},
        // restart at zero
        '{8'hdf, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        // largest offset lands on position 1791
        '{8'h75, 1'b1, 32'hffff_ffff, 1'b1, 1'b1, 8'h00},
        // continues after the run end
        '{8'h5a, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 8'h00},
        // last position, then wrap to zero
        '{8'h3c, 1'b1, 32'd4863,      1'b0, 1'b0, 8'h00},
        '{8'hc3, 1'b0, 32'h5555_5555, 1'b1, 1'b0, 8'h00},
        '{8'h81, 1'b0, 32'haaaa_aaaa, 1'b0, 1'b0, 8'h00},
        // offset equal to the period
        '{8'h00, 1'b1, 32'd4864,      1'b0, 1'b0, 8'h00},
        // largest rotation
        '{8'h00, 1'b1, 32'd56,        1'b0, 1'b0, 8'h00},
        '{8'hff, 1'b1, 32'd57,        1'b1, 1'b0, 8'h00},
        // run ending one position short of the wrap point
        '{8'hff, 1'b1, 32'd9723,      1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 8'h00},
        '{8'ha5, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 8'h00},
        '{8'h5a, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 8'h00},
        // high position bits feed the index
        '{8'h12, 1'b1, 32'h8000_0000, 1'b0, 1'b0, 8'h00},
        '{8'h34, 1'b1, 32'h1234_5678, 1'b1, 1'b0, 8'h00},
        '{8'h56, 1'b1, 32'h0000_12ff, 1'b0, 1'b0, 8'h00},
        '{8'h78, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 8'h00},
        '{8'hff, 1'b1, 32'hffff_fffe, 1'b1, 1'b0, 8'h00}
    };

    image_stream_byte_decipher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // limit on the whole run
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // plain byte for a cipher byte at a keystream position
    function automatic logic [7:0] decipher_byte(input logic [7:0] cbyte,
                                                 input logic [12:0] pos);
        logic [8:0] idx;
        logic [2:0] rot;
        logic [7:0] mixed;
        idx   = {1'b0, pos[7:0]} + {4'b0, pos[12:8]};
        rot   = idx[5:3];
        mixed = cbyte ^ KEY_BYTES[idx[7:0]];
        return (mixed >> rot) | (mixed << (4'd8 - {1'b0, rot}));
    endfunction

    // idle cycles for one item, with stretches of no idling
    function automatic int idle_draw(input int count);
        if ((count / 50) % 4 == 1)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // offer one item, starting and ending at a falling edge
    task automatic send_byte(input logic [7:0] cipher, input logic restart,
                             input logic [31:0] offset, input logic last,
                             input logic typed, input logic [7:0] typed_plain);
        int            gap;
        logic [12:0]   pos;
        plain_result_t want;
        gap = idle_draw(sent_count);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {offset, cipher};
        s_tuser  <= restart;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        // keystream position for this item and the next
        if (restart)
            pos = 13'(offset % KEY_PERIOD);
        else
            pos = key_pos;
        key_pos = (pos >= POS_TOP) ? 13'd0 : pos + 13'd1;
        want.plain   = typed ? typed_plain : decipher_byte(cipher, pos);
        want.run_end = last;
        pending_plain.push_back(want);
        sent_count++;
        @(negedge aclk);
    endtask

    // stimulus
    initial begin
        int          run_len;
        int unsigned wrap_base;
        logic [31:0] run_offset;
        logic        run_restart;
        logic        item_restart;
        logic        item_last;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        key_pos        = 13'd0;
        mismatch_count = 0;
        sent_count     = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].cipher, directed_rows[i].restart,
                      directed_rows[i].offset, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].plain);

        // random runs: mostly continuous keystream, some restarts and noise
        while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            run_len     = $urandom_range(1, 24);
            run_restart = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                wrap_base  = $urandom_range(0, 883000);
                run_offset = 32'(wrap_base * 4864) + 32'($urandom_range(4840, 4863));
            end else begin
                run_offset = $urandom;
            end
            for (int k = 0; k < run_len; k++) begin
                // drain everything once, partway through the random items
                if (sent_count == DIRECTED_ROWS + 400) begin
                    s_tvalid <= 1'b0;
                    while (pending_plain.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
                item_restart = (k == 0) ? run_restart : ($urandom_range(0, 19) == 0);
                item_last    = (k == run_len - 1) || ($urandom_range(0, 15) == 0);
                send_byte(8'($urandom), item_restart,
                          (k == 0) ? run_offset : $urandom, item_last, 1'b0, 8'h00);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (pending_plain.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_plain.size() != 0) begin
            mismatch_count += pending_plain.size();
            $display("missing %0d result items", pending_plain.size());
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side back pressure
    initial begin
        int stall;
        m_tready   = 1'b0;
        recv_count = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_draw(recv_count);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            recv_count++;
            @(negedge aclk);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        plain_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_plain.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: plain %02h run_end %0b", m_tdata, m_tlast);
            end else begin
                want = pending_plain.pop_front();
                if (m_tdata !== want.plain || m_tlast !== want.run_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: plain exp %02h got %02h, run_end exp %0b got %0b",
                                 want.plain, m_tdata, want.run_end, m_tlast);
                end
            end
        end
    end

endmodule

// ----- image_stream_byte_decipher.f -----
hdl/isbd_pkg.sv
hdl/image_stream_byte_decipher.sv
hdl/isbd_checker.sv
tb/sv/testbench.sv
